// ===== hdl/c2d_pkg.sv =====
// ----------------------------------------------------------------------------
// c2d_pkg
// shared types and constants of the integer valid 2d convolution block
// ----------------------------------------------------------------------------
package c2d_pkg;

   localparam int unsigned MaxKernel  = 16;
   localparam int unsigned MaxWidth   = 1024;
   localparam int unsigned KIdxW      = $clog2(MaxKernel);
   localparam int unsigned ColW       = $clog2(MaxWidth);
   localparam int unsigned KDepth     = MaxKernel * MaxKernel;
   localparam int unsigned LDepth     = MaxKernel * MaxWidth;
   localparam int unsigned KAddrW     = $clog2(KDepth);
   localparam int unsigned LAddrW     = $clog2(LDepth);
   localparam int unsigned DataW      = 32;
   localparam int unsigned RowW       = 16;
   localparam int unsigned KDimW      = 5;
   localparam int unsigned ICDimW     = 11;
   localparam int unsigned CsrDataW   = 16;
   localparam int unsigned CsrIdxW    = 2;

   localparam logic FUNC_KERNEL = 1'b0;
   localparam logic FUNC_IMAGE  = 1'b1;

   localparam logic [CsrIdxW-1:0] CSR_IMAGE_ROWS  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_IMAGE_COLS  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_KERNEL_ROWS = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_KERNEL_COLS = 2'd3;

   typedef struct packed {
      logic [RowW-1:0]   image_rows;
      logic [ICDimW-1:0] image_cols;
      logic [KDimW-1:0]  kernel_rows;
      logic [KDimW-1:0]  kernel_cols;
   } dims_type;

   typedef struct packed {
      logic              func;
      logic [KAddrW-1:0] kaddr;
      logic [LAddrW-1:0] laddr;
      logic [DataW-1:0]  value;
      logic              emit;
      logic [RowW-1:0]   i0;
      logic [ColW-1:0]   j0;
      logic              last;
   } cmd_type;

endpackage

// ===== hdl/conv2d_valid_integer.sv =====
// ----------------------------------------------------------------------------
// conv2d_valid_integer
// valid 2d convolution of signed 32-bit integers with a line store
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// req       in         req_valid/ready    req_func, req_sample_value
// rsp       out        rsp_valid/ready    rsp_result_value, rsp_out_row/col, rsp_last
// csr       in         csr_write_enable   csr_index, csr_write_data
//
// kernel and non-emitting image requests are a single store write in the back end
// an emitting image request is issued window product by window product in MAC, drained
// in DRAIN and handed off in OUT, through the single multiply-accumulate unit (one product a cycle)
// a two-entry command queue lets requests be taken while a result waits
// reset is synchronous; store contents are not cleared
// ----------------------------------------------------------------------------
module conv2d_valid_integer import c2d_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [DataW-1:0]    req_sample_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DataW-1:0]    rsp_result_value,
   output logic [RowW-1:0]     rsp_out_row,
   output logic [ColW-1:0]     rsp_out_col,
   output logic                rsp_last,
   input  logic                csr_write_enable,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_write_data
);

   logic [RowW-1:0]   image_rows_ff;
   logic [ICDimW-1:0] image_cols_ff;
   logic [KDimW-1:0]  kernel_rows_ff;
   logic [KDimW-1:0]  kernel_cols_ff;
   dims_type          dims;
   logic              cmd_valid;
   logic              cmd_pop;
   cmd_type           cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff  <= RowW'(1);
         image_cols_ff  <= ICDimW'(1);
         kernel_rows_ff <= KDimW'(1);
         kernel_cols_ff <= KDimW'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_ROWS:  image_rows_ff  <= csr_write_data;
            CSR_IMAGE_COLS:  image_cols_ff  <= csr_write_data[ICDimW-1:0];
            CSR_KERNEL_ROWS: kernel_rows_ff <= csr_write_data[KDimW-1:0];
            CSR_KERNEL_COLS: kernel_cols_ff <= csr_write_data[KDimW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      dims.image_rows  = (image_rows_ff == '0) ? RowW'(1) : image_rows_ff;
      dims.image_cols  = (image_cols_ff == '0) ? ICDimW'(1) :
                         (image_cols_ff > ICDimW'(MaxWidth)) ? ICDimW'(MaxWidth) : image_cols_ff;
      dims.kernel_rows = (kernel_rows_ff == '0) ? KDimW'(1) :
                         (kernel_rows_ff > KDimW'(MaxKernel)) ? KDimW'(MaxKernel) : kernel_rows_ff;
      dims.kernel_cols = (kernel_cols_ff == '0) ? KDimW'(1) :
                         (kernel_cols_ff > KDimW'(MaxKernel)) ? KDimW'(MaxKernel) : kernel_cols_ff;
   end

   c2d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .dims             (dims),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_sample_value (req_sample_value),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   c2d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .dims             (dims),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== hdl/c2d_ram.sv =====
// ----------------------------------------------------------------------------
// c2d_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module c2d_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/c2d_front.sv =====
// ----------------------------------------------------------------------------
// c2d_front
// accepts requests, tracks kernel and image positions, queues commands
// ----------------------------------------------------------------------------
module c2d_front import c2d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dims_type         dims,
   input  logic             csr_write_enable,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic [DataW-1:0] req_sample_value,
   output logic             cmd_valid,
   output cmd_type          cmd,
   input  logic             cmd_pop
);

   cmd_type          fifo_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic [KDimW-1:0] ki_ff, ki_in;
   logic [KDimW-1:0] kj_ff, kj_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic [ColW-1:0]  col_ff, col_in;

   logic             accept;
   logic             push;
   logic             kernel_full;
   logic [RowW-1:0]  r;
   logic [ColW-1:0]  c;
   logic [KIdxW-1:0] kr_flip;
   logic [KIdxW-1:0] kc_flip;
   logic [RowW:0]    r_plus;
   logic [ICDimW-1:0] c_plus;
   cmd_type          new_cmd;

   assign req_ready   = (count_ff != 2'd2);
   assign accept      = req_valid && req_ready;
   assign kernel_full = (ki_ff == dims.kernel_rows);

   always_comb begin
      r = row_ff;
      c = col_ff;
      if ((r >= dims.image_rows) || ({1'b0, c} >= dims.image_cols)) begin
         r = '0;
         c = '0;
      end
      r_plus  = {1'b0, r} + 1'b1;
      c_plus  = {1'b0, c} + 1'b1;
      kr_flip = KIdxW'(dims.kernel_rows - 1'b1 - ki_ff);
      kc_flip = KIdxW'(dims.kernel_cols - 1'b1 - kj_ff);

      new_cmd.func  = req_func;
      new_cmd.kaddr = {kr_flip, kc_flip};
      new_cmd.laddr = {r[KIdxW-1:0], c};
      new_cmd.value = req_sample_value;
      new_cmd.emit  = (r_plus >= (RowW+1)'(dims.kernel_rows)) &&
                      (c_plus >= ICDimW'(dims.kernel_cols));
      new_cmd.i0    = RowW'(r_plus - (RowW+1)'(dims.kernel_rows));
      new_cmd.j0    = ColW'(c_plus - ICDimW'(dims.kernel_cols));
      new_cmd.last  = (r_plus == (RowW+1)'(dims.image_rows)) && (c_plus == dims.image_cols);

      push = accept && ((req_func == FUNC_IMAGE) || !kernel_full);

      ki_in  = ki_ff;
      kj_in  = kj_ff;
      row_in = row_ff;
      col_in = col_ff;
      if (accept && (req_func == FUNC_KERNEL) && !kernel_full) begin
         if ((kj_ff + 1'b1) == dims.kernel_cols) begin
            kj_in = '0;
            ki_in = ki_ff + 1'b1;
         end else begin
            kj_in = kj_ff + 1'b1;
         end
      end
      if (accept && (req_func == FUNC_IMAGE)) begin
         if (c_plus >= dims.image_cols) begin
            col_in = '0;
            row_in = (r_plus >= (RowW+1)'(dims.image_rows)) ? '0 : RowW'(r_plus);
         end else begin
            col_in = ColW'(c_plus);
            row_in = r;
         end
      end
      if (csr_write_enable) begin
         row_in = '0;
         col_in = '0;
         if ((csr_index == CSR_KERNEL_ROWS) || (csr_index == CSR_KERNEL_COLS)) begin
            ki_in = '0;
            kj_in = '0;
         end
      end

      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
         ki_ff     <= '0;
         kj_ff     <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         ki_ff     <= ki_in;
         kj_ff     <= kj_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = fifo_ff[rd_ptr_ff];

endmodule

// ===== hdl/c2d_back.sv =====
// ----------------------------------------------------------------------------
// c2d_back
// executes queued commands: store writes and multiply-accumulate over a window
// ----------------------------------------------------------------------------
module c2d_back import c2d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dims_type         dims,
   input  logic             cmd_valid,
   input  cmd_type          cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [DataW-1:0] rsp_result_value,
   output logic [RowW-1:0]  rsp_out_row,
   output logic [ColW-1:0]  rsp_out_col,
   output logic             rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [KIdxW-1:0] rr_ff, rr_in;
   logic [KIdxW-1:0] cc_ff, cc_in;
   logic             rd_v_ff;
   logic             prod_v_ff;
   logic [DataW-1:0] prod_ff;
   logic [DataW-1:0] acc_ff, acc_in;
   logic [RowW-1:0]  i0_ff;
   logic [ColW-1:0]  j0_ff;
   logic             last_ff;

   logic             issue;
   logic             issue_last;
   logic             kwr;
   logic             lwr;
   logic [KAddrW-1:0] k_rd_addr;
   logic [LAddrW-1:0] l_rd_addr;
   logic [DataW-1:0] k_data;
   logic [DataW-1:0] l_data;
   logic [KIdxW-1:0] lrow;

   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_valid;
   assign kwr        = cmd_pop && (cmd.func == FUNC_KERNEL);
   assign lwr        = cmd_pop && (cmd.func == FUNC_IMAGE);
   assign issue      = (state_ff == ST_MAC);
   assign issue_last = ({1'b0, rr_ff} == KDimW'(dims.kernel_rows - 1'b1)) &&
                       ({1'b0, cc_ff} == KDimW'(dims.kernel_cols - 1'b1));
   assign lrow       = i0_ff[KIdxW-1:0] + rr_ff;
   assign k_rd_addr  = {rr_ff, cc_ff};
   assign l_rd_addr  = {lrow, ColW'(j0_ff + ColW'(cc_ff))};

   c2d_ram #(.WIDTH(DataW), .DEPTH(KDepth)) u_kernel_ram (
      .clock   (clock),
      .wr_en   (kwr),
      .wr_addr (cmd.kaddr),
      .wr_data (cmd.value),
      .rd_addr (k_rd_addr),
      .rd_data (k_data)
   );

   c2d_ram #(.WIDTH(DataW), .DEPTH(LDepth)) u_line_ram (
      .clock   (clock),
      .wr_en   (lwr),
      .wr_addr (cmd.laddr),
      .wr_data (cmd.value),
      .rd_addr (l_rd_addr),
      .rd_data (l_data)
   );

   always_comb begin
      state_in = state_ff;
      rr_in    = rr_ff;
      cc_in    = cc_ff;
      acc_in   = prod_v_ff ? acc_ff + prod_ff : acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rr_in = '0;
            cc_in = '0;
            if (lwr && cmd.emit) begin
               state_in = ST_MAC;
               acc_in   = '0;
            end
         end
         ST_MAC: begin
            if (issue_last) begin
               state_in = ST_DRAIN;
            end else if ({1'b0, cc_ff} == KDimW'(dims.kernel_cols - 1'b1)) begin
               cc_in = '0;
               rr_in = rr_ff + 1'b1;
            end else begin
               cc_in = cc_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_v_ff   <= issue;
         prod_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      rr_ff   <= rr_in;
      cc_ff   <= cc_in;
      acc_ff  <= acc_in;
      prod_ff <= DataW'(k_data * l_data);
      if (lwr) begin
         i0_ff   <= cmd.i0;
         j0_ff   <= cmd.j0;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_result_value = acc_ff;
   assign rsp_out_row      = i0_ff;
   assign rsp_out_col      = j0_ff;
   assign rsp_last         = last_ff;

`ifndef SYNTHESIS
   a_no_pop_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE))
      else $error("command popped while busy");
   a_out_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rd_v_ff && !prod_v_ff))
      else $error("result shown with products in flight");
   a_read_follows_issue: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff |-> $past(state_ff == ST_MAC))
      else $error("read data without issue");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_value)))
      else $error("result changed while stalled");
`endif

endmodule

// ===== tb/sv/conv2d_window_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_window_checker
// watches the request, result and csr ports of the valid 2d convolution,
// predicts every window sum from its own copy of the stores and compares
// each result field against the oldest predicted window in order
// ----------------------------------------------------------------------------
module conv2d_window_checker import c2d_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_func,
   input  logic [DataW-1:0]    req_sample_value,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [DataW-1:0]    rsp_result_value,
   input  logic [RowW-1:0]     rsp_out_row,
   input  logic [ColW-1:0]     rsp_out_col,
   input  logic                rsp_last,
   input  logic                csr_write_enable,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_write_data,
   output int                  fail_count,
   output int                  pending
);

   typedef struct {
      logic [DataW-1:0] sum;
      logic [RowW-1:0]  row;
      logic [ColW-1:0]  col;
      logic             last;
   } window_type;

   window_type       expected_windows[$];
   logic [DataW-1:0] kernel_mem[KDepth];
   logic [DataW-1:0] line_mem[LDepth];
   dims_type         dims;
   int unsigned      kernel_count;
   int unsigned      row_pos;
   int unsigned      col_pos;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // one accepted request through the convolution
   task automatic predict_request(logic func, logic [DataW-1:0] v);
      int unsigned kh, kw, ir, ic, r, c, i0, j0;
      logic [DataW-1:0] acc;
      window_type w;
      kh = clamp_dim(dims.kernel_rows, MaxKernel);
      kw = clamp_dim(dims.kernel_cols, MaxKernel);
      ir = clamp_dim(dims.image_rows, 65535);
      ic = clamp_dim(dims.image_cols, MaxWidth);
      if (func == FUNC_KERNEL) begin
         if (kernel_count < kh * kw) begin
            kernel_mem[(kh - 1 - kernel_count / kw) * MaxKernel
                       + (kw - 1 - kernel_count % kw)] = v;
            kernel_count++;
         end
         return;
      end
      r = row_pos;
      c = col_pos;
      if (r >= ir || c >= ic) begin
         r = 0;
         c = 0;
      end
      line_mem[(r % MaxKernel) * MaxWidth + c] = v;
      if (r + 1 >= kh && c + 1 >= kw) begin
         i0 = r + 1 - kh;
         j0 = c + 1 - kw;
         acc = '0;
         for (int rr = 0; rr < kh; rr++) begin
            for (int cc = 0; cc < kw; cc++) begin
               acc += line_mem[((i0 + rr) % MaxKernel) * MaxWidth + j0 + cc]
                      * kernel_mem[rr * MaxKernel + cc];
            end
         end
         w.sum  = acc;
         w.row  = i0[RowW-1:0];
         w.col  = j0[ColW-1:0];
         w.last = (r == ir - 1 && c == ic - 1);
         expected_windows.push_back(w);
      end
      c++;
      if (c >= ic) begin
         c = 0;
         r++;
         if (r >= ir) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endtask

   always @(posedge clock) begin
      window_type w;
      if (reset) begin
         expected_windows.delete();
         dims.image_rows  = RowW'(1);
         dims.image_cols  = ICDimW'(1);
         dims.kernel_rows = KDimW'(1);
         dims.kernel_cols = KDimW'(1);
         kernel_count = 0;
         row_pos = 0;
         col_pos = 0;
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_ROWS: dims.image_rows = csr_write_data[RowW-1:0];
               CSR_IMAGE_COLS: dims.image_cols = csr_write_data[ICDimW-1:0];
               CSR_KERNEL_ROWS: begin
                  dims.kernel_rows = csr_write_data[KDimW-1:0];
                  kernel_count = 0;
               end
               CSR_KERNEL_COLS: begin
                  dims.kernel_cols = csr_write_data[KDimW-1:0];
                  kernel_count = 0;
               end
               default: ;
            endcase
            row_pos = 0;
            col_pos = 0;
         end
         if (req_valid && req_ready) predict_request(req_func, req_sample_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_windows.size() == 0) begin
               $display("%0t unexpected result: sum %h row %0d col %0d last %0d",
                        $time, rsp_result_value, rsp_out_row, rsp_out_col, rsp_last);
               fail_count++;
            end else begin
               w = expected_windows.pop_front();
               if (rsp_result_value !== w.sum) begin
                  $display("%0t sum: expected %h actual %h", $time, w.sum,
                           rsp_result_value);
                  fail_count++;
               end
               if (rsp_out_row !== w.row) begin
                  $display("%0t out_row: expected %0d actual %0d", $time, w.row,
                           rsp_out_row);
                  fail_count++;
               end
               if (rsp_out_col !== w.col) begin
                  $display("%0t out_col: expected %0d actual %0d", $time, w.col,
                           rsp_out_col);
                  fail_count++;
               end
               if (rsp_last !== w.last) begin
                  $display("%0t last: expected %0d actual %0d", $time, w.last,
                           rsp_last);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_windows.size();
   end

endmodule

// ===== tb/sv/tb_conv2d_valid_integer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_valid_integer
// drives kernel loads and image streams through the valid 2d convolution
// over many matrix and kernel sizes, with random request gaps and result
// stalls; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_conv2d_valid_integer;
   import c2d_pkg::*;

   localparam int StallLimit = 5000;
   localparam int DrainCycles = 300;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_func = FUNC_KERNEL;
   logic [DataW-1:0]    req_sample_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DataW-1:0]    rsp_result_value;
   logic [RowW-1:0]     rsp_out_row;
   logic [ColW-1:0]     rsp_out_col;
   logic                rsp_last;
   logic                csr_write_enable = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_IMAGE_ROWS;
   logic [CsrDataW-1:0] csr_write_data = '0;
   int                  fail_count;
   int                  pending;
   int                  idle_cycles = 0;
   int                  rsp_hold = 0;
   int                  sent = 0;
   bit                  burst = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   conv2d_valid_integer dut (.*);

   conv2d_window_checker checker_inst (.*);

   // result side back-pressure
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_ready && rsp_valid) begin
         w = burst ? 0 : $urandom_range(0, 5);
         rsp_ready <= (w == 0);
         rsp_hold  <= w;
      end else if (!rsp_ready) begin
         if (rsp_hold <= 1) rsp_ready <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic logic [DataW-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return DataW'($signed($urandom_range(0, 16)) - 8);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom_range(0, 1000);
      endcase
   endfunction

   task automatic send(logic func, logic [DataW-1:0] v);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_sample_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_dims(int unsigned ir, int unsigned ic, int unsigned kr,
                             int unsigned kc);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_IMAGE_ROWS;  csr_write_data <= CsrDataW'(ir);
      @(posedge clock);
      csr_index <= CSR_IMAGE_COLS;  csr_write_data <= CsrDataW'(ic);
      @(posedge clock);
      csr_index <= CSR_KERNEL_ROWS; csr_write_data <= CsrDataW'(kr);
      @(posedge clock);
      csr_index <= CSR_KERNEL_COLS; csr_write_data <= CsrDataW'(kc);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_job(int unsigned ir, int unsigned ic, int unsigned kr,
                          int unsigned kc, int kernel_items, int image_items,
                          bit noise);
      settle();
      burst = ($urandom_range(0, 3) == 0);
      write_dims(ir, ic, kr, kc);
      for (int k = 0; k < kernel_items; k++) send(FUNC_KERNEL, pick_sample());
      for (int k = 0; k < image_items; k++) begin
         if (noise && $urandom_range(0, 7) == 0) send(FUNC_KERNEL, pick_sample());
         send(FUNC_IMAGE, pick_sample());
      end
   endtask

   initial begin
      int unsigned ir, ic, kr, kc, kh, kw, n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // small image with extra kernel requests
      run_job(3, 4, 2, 2, 6, 12, 0);
      // out of range dimensions act as one
      run_job(0, 0, 0, 0, 1, 3, 0);
      // kernel larger than image
      run_job(2, 2, 3, 3, 9, 4, 0);
      // same dims again, kernel only partly reloaded
      run_job(3, 3, 2, 2, 4, 0, 0);
      run_job(3, 3, 2, 2, 1, 9, 0);
      // clamped kernel dimensions and widest image
      run_job(16, 4, 31, 1, 16, 64, 0);
      run_job(1, 20, 1, 17, 16, 20, 0);
      run_job(65535, 2047, 1, 2, 2, 40, 0);
      run_job(16, 17, 16, 16, 256, 272, 0);

      while (sent < 1200) begin
         kr = $urandom_range(1, 4);
         kc = $urandom_range(1, 4);
         ir = $urandom_range(1, 8);
         ic = $urandom_range(1, 40);
         case ($urandom_range(0, 15))
            0: kr = 0;
            1: kc = $urandom_range(17, 31);
            2: ic = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047);
            3: ir = $urandom_range(0, 1) ? 0 : 65535;
            4: begin
               kr = $urandom_range(5, 16);
               kc = $urandom_range(5, 16);
            end
            default: ;
         endcase
         kh = clamp_dim(kr, MaxKernel);
         kw = clamp_dim(kc, MaxKernel);
         n = clamp_dim(ir, 65535) * clamp_dim(ic, MaxWidth);
         n = n * $urandom_range(1, 2) + $urandom_range(0, 5);
         if (n > 150) n = $urandom_range(60, 150);
         run_job(ir, ic, kr, kc, kh * kw + $urandom_range(0, 2), n,
                 $urandom_range(0, 3) == 0);
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/c2d_pkg.sv
hdl/c2d_ram.sv
hdl/c2d_front.sv
hdl/c2d_back.sv
hdl/conv2d_valid_integer.sv
tb/sv/conv2d_window_checker.sv
tb/sv/tb_conv2d_valid_integer.sv
